// File: src/rrtnn_pkg.sv
// Shared types, codes and helpers for the RRT node table with nearest search.
// Used by every module under src; no dependencies.
package rrtnn_pkg;

  localparam int DEPTH   = 64;
  localparam int CW      = 32;
  localparam int IDX_W   = $clog2(DEPTH);
  localparam int CNT_W   = IDX_W + 1;
  localparam int PROD_W  = 2 * CW;
  localparam int DIST_W  = PROD_W + 2;
  localparam int IN_DW   = 120;
  localparam int OUT_DW  = 128;

  typedef logic signed [CW-1:0] coord_t;
  typedef logic [IDX_W-1:0]     idx_t;
  typedef logic [CNT_W-1:0]     cnt_t;
  typedef logic [DIST_W-1:0]    dist_t;

  typedef struct packed {
    coord_t z;
    coord_t y;
    coord_t x;
  } crd_t;

  typedef enum logic [2:0] {
    F_ROOT, F_APPEND, F_REMOVE, F_READ, F_NEAREST, F_SETPAR, F_PATH, F_RDPAR
  } func_t;

  typedef enum logic [1:0] {
    ST_OK, ST_BAD_IDX, ST_FULL, ST_TOO_LONG
  } status_t;

  typedef enum logic [1:0] {
    CFG_ROOT_X, CFG_ROOT_Y, CFG_ROOT_Z
  } cfg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DEC, S_REM_CAP, S_REM_WR, S_READ_CAP, S_RP_CHK,
    S_NN_LD, S_NN_DIST, S_PATH_CHK, S_POP_LD, S_OUT
  } state_t;

  // write-side controls for the node store
  typedef struct packed {
    logic crd_we;
    logic par_we;
    logic tag_we;
    logic stk_we;
    idx_t addr;
  } mem_wr_t;

  function automatic logic [CW-1:0] abs_diff(input coord_t a, input coord_t b);
    logic signed [CW:0] d;
    begin
      d = (a > b) ? ({a[CW-1], a} - {b[CW-1], b}) : ({b[CW-1], b} - {a[CW-1], a});
      return d[CW-1:0];
    end
  endfunction

endpackage

// File: src/rrtnn_mem.sv
// Node store: coordinates, parent links, tags and the path stack.
// One write address and one registered read address per cycle. Uses rrtnn_pkg.
module rrtnn_mem (
  input  logic             clk,
  input  rrtnn_pkg::mem_wr_t wr,
  input  rrtnn_pkg::crd_t  wr_crd,
  input  rrtnn_pkg::idx_t  wr_par,
  input  rrtnn_pkg::idx_t  wr_tag,
  input  rrtnn_pkg::idx_t  wr_stk,
  input  rrtnn_pkg::idx_t  rd_addr,
  output rrtnn_pkg::crd_t  rd_crd,
  output rrtnn_pkg::idx_t  rd_par,
  output rrtnn_pkg::idx_t  rd_tag,
  output rrtnn_pkg::idx_t  rd_stk
);
  import rrtnn_pkg::*;

  crd_t crd_mem [DEPTH];
  idx_t par_mem [DEPTH];
  idx_t tag_mem [DEPTH];
  idx_t stk_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr.crd_we) crd_mem[wr.addr] <= wr_crd;
    if (wr.par_we) par_mem[wr.addr] <= wr_par;
    if (wr.tag_we) tag_mem[wr.addr] <= wr_tag;
    if (wr.stk_we) stk_mem[wr.addr] <= wr_stk;
  end

  always_ff @(posedge clk) begin
    rd_crd <= crd_mem[rd_addr];
    rd_par <= par_mem[rd_addr];
    rd_tag <= tag_mem[rd_addr];
    rd_stk <= stk_mem[rd_addr];
  end

endmodule

// File: src/rrtnn_dist.sv
// Squared-distance unit: one shared multiplier squares one axis per cycle.
// sq_dist is valid while done is high. Uses rrtnn_pkg.
module rrtnn_dist (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  rrtnn_pkg::crd_t node,
  input  rrtnn_pkg::crd_t query,
  output logic            done,
  output rrtnn_pkg::dist_t sq_dist
);
  import rrtnn_pkg::*;

  logic [CW-1:0]     d_r [3];
  logic [PROD_W-1:0] prod_r;
  dist_t             acc_r;
  logic [2:0]        cnt_r;
  logic              busy_r;

  assign done    = busy_r && (cnt_r == 3'd4);
  assign sq_dist = acc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 3'd1;
      if (done) busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      d_r[0] <= abs_diff(node.x, query.x);
      d_r[1] <= abs_diff(node.y, query.y);
      d_r[2] <= abs_diff(node.z, query.z);
      acc_r  <= '0;
    end else if (busy_r) begin
      if (cnt_r < 3'd3) prod_r <= d_r[cnt_r[1:0]] * d_r[cnt_r[1:0]];
      if (cnt_r != 3'd0 && cnt_r < 3'd4) acc_r <= acc_r + DIST_W'(prod_r);
    end
  end

endmodule

// File: src/rrt_node_table_nearest.sv
// RRT node table: sequencer, root registers and output register.
// Instantiates rrtnn_mem and rrtnn_dist; uses rrtnn_pkg.
//
// Input beats carry one command (tuser = func). One command is in work at a
// time: in_tready is high only while the sequencer is idle. Each command ends
// in one output beat with tlast set, except a good path query, which emits
// one beat per path node, root first, tlast on the end node.
// Steps from input beat to first output beat:
//   reset root, append, set parent, index errors: decode, then the beat
//   read, read parent: registered store reads, then capture
//   remove: capture the removed row, then one row moved per cycle
//   nearest: one distance run per node; the one multiplier squares one axis
//     per cycle, so each node costs a load, a diff stage and three squares
//   path: walk the parent links onto a stack, then pop one node per beat
// The output register holds its beat while out_tready is low and the block
// waits. Root registers are written through cfg_* at any idle time.
// Reset empties the table (count zero) and clears the root registers; the
// store contents are not cleared, no entry is read before being written.
module rrt_node_table_nearest (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [1:0]                   cfg_index,
  input  logic [31:0]                  cfg_wdata,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  // node_index, coord_x, coord_y, coord_z, parent_index, id_tag, zero pad
  input  logic [rrtnn_pkg::IN_DW-1:0]  in_tdata,
  // func
  input  logic [2:0]                   in_tuser,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  // result_index, out_x, out_y, out_z, out_parent, out_tag, node_count, pad
  output logic [rrtnn_pkg::OUT_DW-1:0] out_tdata,
  output logic                         out_tlast,
  // status
  output logic [1:0]                   out_tuser
);
  import rrtnn_pkg::*;

  state_t  state_r, state_nxt;
  crd_t    root_r;
  func_t   func_r;
  idx_t    idx_r, par_r, tag_r;
  crd_t    q_r;
  cnt_t    cnt_r, cnt_nxt;
  cnt_t    i_r, i_nxt;
  cnt_t    len_r, len_nxt;
  idx_t    pos_r, pos_nxt;
  dist_t   best_r, best_nxt;
  idx_t    best_i_r, best_i_nxt;

  idx_t    o_idx_r, o_idx_nxt;
  crd_t    o_crd_r, o_crd_nxt;
  idx_t    o_par_r, o_par_nxt;
  idx_t    o_tag_r, o_tag_nxt;
  cnt_t    o_cnt_r, o_cnt_nxt;
  logic    o_last_r, o_last_nxt;
  status_t o_st_r, o_st_nxt;

  mem_wr_t mw;
  crd_t    w_crd;
  idx_t    w_par, w_tag, w_stk;
  idx_t    rd_addr;
  crd_t    rd_crd;
  idx_t    rd_par, rd_tag, rd_stk;

  logic    dist_start, dist_done;
  dist_t   sq_dist;

  logic    in_acc, out_acc;
  logic    bad_idx, full, rem_first_more, rem_more, nn_more, nn_better;
  logic    par_bad, path_long, o_zero;

  assign in_acc  = in_tvalid && in_tready;
  assign out_acc = out_tvalid && out_tready;

  assign bad_idx        = {1'b0, idx_r} >= cnt_r;
  assign full           = cnt_r == cnt_t'(DEPTH);
  assign rem_first_more = ({1'b0, idx_r} + cnt_t'(1)) < cnt_r;
  assign rem_more       = (i_r + cnt_t'(2)) < cnt_r;
  assign nn_more        = (i_r + cnt_t'(1)) < cnt_r;
  assign nn_better      = (i_r == '0) || (sq_dist < best_r);
  assign par_bad        = {1'b0, rd_par} >= cnt_r;
  assign path_long      = len_r >= cnt_t'(DEPTH);

  rrtnn_mem u_mem (
    .clk     (clk),
    .wr      (mw),
    .wr_crd  (w_crd),
    .wr_par  (w_par),
    .wr_tag  (w_tag),
    .wr_stk  (w_stk),
    .rd_addr (rd_addr),
    .rd_crd  (rd_crd),
    .rd_par  (rd_par),
    .rd_tag  (rd_tag),
    .rd_stk  (rd_stk)
  );

  rrtnn_dist u_dist (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (dist_start),
    .node    (rd_crd),
    .query   (q_r),
    .done    (dist_done),
    .sq_dist (sq_dist)
  );

  // root registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      root_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ROOT_X: root_r.x <= coord_t'(cfg_wdata);
        CFG_ROOT_Y: root_r.y <= coord_t'(cfg_wdata);
        CFG_ROOT_Z: root_r.z <= coord_t'(cfg_wdata);
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_acc) state_nxt = S_DEC;
      S_DEC: begin
        unique case (func_r)
          F_ROOT, F_APPEND, F_SETPAR: state_nxt = S_OUT;
          F_NEAREST: state_nxt = (cnt_r == '0) ? S_OUT : S_NN_LD;
          F_REMOVE:  state_nxt = bad_idx ? S_OUT : S_REM_CAP;
          F_READ:    state_nxt = bad_idx ? S_OUT : S_READ_CAP;
          F_RDPAR:   state_nxt = bad_idx ? S_OUT : S_RP_CHK;
          F_PATH:    state_nxt = bad_idx ? S_OUT : S_PATH_CHK;
          default:   state_nxt = S_OUT;
        endcase
      end
      S_REM_CAP:  state_nxt = rem_first_more ? S_REM_WR : S_OUT;
      S_REM_WR:   if (!rem_more) state_nxt = S_OUT;
      S_READ_CAP: state_nxt = S_OUT;
      S_RP_CHK:   state_nxt = par_bad ? S_OUT : S_READ_CAP;
      S_NN_LD:    state_nxt = S_NN_DIST;
      S_NN_DIST:  if (dist_done) state_nxt = nn_more ? S_NN_LD : S_OUT;
      S_PATH_CHK: begin
        if (rd_tag == '0) state_nxt = S_POP_LD;
        else if (par_bad || path_long) state_nxt = S_OUT;
      end
      S_POP_LD:   state_nxt = S_OUT;
      S_OUT:      if (out_acc) state_nxt = o_last_r ? S_IDLE : S_POP_LD;
      default:    state_nxt = S_IDLE;
    endcase
  end

  // datapath and store control
  always_comb begin
    cnt_nxt    = cnt_r;
    i_nxt      = i_r;
    len_nxt    = len_r;
    pos_nxt    = pos_r;
    best_nxt   = best_r;
    best_i_nxt = best_i_r;
    o_idx_nxt  = o_idx_r;
    o_crd_nxt  = o_crd_r;
    o_par_nxt  = o_par_r;
    o_tag_nxt  = o_tag_r;
    o_cnt_nxt  = o_cnt_r;
    o_last_nxt = o_last_r;
    o_st_nxt   = o_st_r;
    o_zero     = 1'b0;
    mw         = '0;
    w_crd      = rd_crd;
    w_par      = rd_par;
    w_tag      = rd_tag;
    w_stk      = rd_par;
    rd_addr    = '0;
    dist_start = 1'b0;

    unique case (state_r)
      S_DEC: begin
        o_idx_nxt  = '0;
        o_last_nxt = 1'b1;
        o_st_nxt   = ST_OK;
        o_zero     = 1'b1;
        unique case (func_r)
          F_ROOT: begin
            mw.crd_we = 1'b1;
            mw.par_we = 1'b1;
            mw.tag_we = 1'b1;
            w_crd     = root_r;
            w_par     = '0;
            w_tag     = '0;
            cnt_nxt   = cnt_t'(1);
          end
          F_APPEND: begin
            if (full) begin
              o_st_nxt = ST_FULL;
            end else begin
              mw.crd_we = 1'b1;
              mw.par_we = 1'b1;
              mw.tag_we = 1'b1;
              mw.addr   = cnt_r[IDX_W-1:0];
              w_crd     = q_r;
              w_par     = par_r;
              w_tag     = tag_r;
              cnt_nxt   = cnt_r + cnt_t'(1);
            end
          end
          F_NEAREST: begin
            if (cnt_r == '0) o_st_nxt = ST_BAD_IDX;
            i_nxt = '0;
          end
          F_SETPAR: begin
            if (bad_idx) begin
              o_st_nxt = ST_BAD_IDX;
            end else begin
              mw.par_we = 1'b1;
              mw.addr   = idx_r;
              w_par     = par_r;
            end
          end
          default: begin
            if (bad_idx) o_st_nxt = ST_BAD_IDX;
            rd_addr = idx_r;
            if (func_r == F_PATH) begin
              mw.stk_we = !bad_idx;
              w_stk     = idx_r;
              len_nxt   = cnt_t'(1);
            end
          end
        endcase
      end
      S_REM_CAP: begin
        o_crd_nxt = rd_crd;
        o_par_nxt = rd_par;
        o_tag_nxt = rd_tag;
        i_nxt     = {1'b0, idx_r};
        rd_addr   = idx_r + idx_t'(1);
        if (!rem_first_more) cnt_nxt = cnt_r - cnt_t'(1);
      end
      S_REM_WR: begin
        mw.crd_we = 1'b1;
        mw.par_we = 1'b1;
        mw.tag_we = 1'b1;
        mw.addr   = i_r[IDX_W-1:0];
        i_nxt     = i_r + cnt_t'(1);
        rd_addr   = i_r[IDX_W-1:0] + idx_t'(2);
        if (!rem_more) cnt_nxt = cnt_r - cnt_t'(1);
      end
      S_READ_CAP: begin
        o_crd_nxt = rd_crd;
        o_par_nxt = rd_par;
        o_tag_nxt = rd_tag;
      end
      S_RP_CHK: begin
        rd_addr = rd_par;
        if (par_bad) o_st_nxt = ST_BAD_IDX;
      end
      S_NN_LD: dist_start = 1'b1;
      S_NN_DIST: begin
        if (dist_done) begin
          if (nn_better) begin
            best_nxt   = sq_dist;
            best_i_nxt = i_r[IDX_W-1:0];
          end
          i_nxt     = i_r + cnt_t'(1);
          rd_addr   = i_r[IDX_W-1:0] + idx_t'(1);
          o_idx_nxt = nn_better ? i_r[IDX_W-1:0] : best_i_r;
        end
      end
      S_PATH_CHK: begin
        if (rd_tag == '0) begin
          pos_nxt = len_r[IDX_W-1:0] - idx_t'(1);
          rd_addr = pos_nxt;
        end else if (par_bad) begin
          o_st_nxt = ST_BAD_IDX;
        end else if (path_long) begin
          o_st_nxt = ST_TOO_LONG;
        end else begin
          mw.stk_we = 1'b1;
          mw.addr   = len_r[IDX_W-1:0];
          w_stk     = rd_par;
          len_nxt   = len_r + cnt_t'(1);
          rd_addr   = rd_par;
        end
      end
      S_POP_LD: begin
        o_idx_nxt  = rd_stk;
        o_last_nxt = (pos_r == '0);
      end
      S_OUT: begin
        // step the stack pointer only once the beat has gone
        if (out_acc && !o_last_r) begin
          pos_nxt = pos_r - idx_t'(1);
          rd_addr = pos_nxt;
        end
      end
      default: ;
    endcase

    if (o_zero) begin
      o_crd_nxt = '0;
      o_par_nxt = '0;
      o_tag_nxt = '0;
    end
    if (state_nxt == S_OUT && state_r != S_OUT) o_cnt_nxt = cnt_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      func_r <= func_t'(in_tuser);
      idx_r  <= in_tdata[5:0];
      q_r.x  <= in_tdata[37:6];
      q_r.y  <= in_tdata[69:38];
      q_r.z  <= in_tdata[101:70];
      par_r  <= in_tdata[107:102];
      tag_r  <= in_tdata[113:108];
    end
    i_r      <= i_nxt;
    len_r    <= len_nxt;
    pos_r    <= pos_nxt;
    best_r   <= best_nxt;
    best_i_r <= best_i_nxt;
    o_idx_r  <= o_idx_nxt;
    o_crd_r  <= o_crd_nxt;
    o_par_r  <= o_par_nxt;
    o_tag_r  <= o_tag_nxt;
    o_cnt_r  <= o_cnt_nxt;
    o_last_r <= o_last_nxt;
    o_st_r   <= o_st_nxt;
  end

  // handshake outputs
  always_comb begin
    in_tready  = (state_r == S_IDLE);
    out_tvalid = (state_r == S_OUT);
  end

  assign out_tdata = {7'd0, o_cnt_r, o_tag_r, o_par_r,
                      o_crd_r.z, o_crd_r.y, o_crd_r.x, o_idx_r};
  assign out_tlast = o_last_r;
  assign out_tuser = o_st_r;

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input taken while a result is pending");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= cnt_t'(DEPTH))
    else $error("node count beyond table depth");

  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != ST_OK) |-> out_tlast)
    else $error("error beat not marked last");

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && out_tlast |=> in_tready)
    else $error("not idle after final beat");

endmodule
